[sv/cmsd_pkg.sv]
package cmsd_pkg;

    // Input actions
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    // Result event kinds
    localparam logic [3:0] KIND_NOTE   = 4'd0;
    localparam logic [3:0] KIND_PROG   = 4'd1;
    localparam logic [3:0] KIND_CTRL   = 4'd2;
    localparam logic [3:0] KIND_LEND   = 4'd3;
    localparam logic [3:0] KIND_LSTART = 4'd4;
    localparam logic [3:0] KIND_SEND   = 4'd5;
    localparam logic [3:0] KIND_DELAY  = 4'd6;
    localparam logic [3:0] KIND_UNK    = 4'd7;
    localparam logic [3:0] KIND_TICK   = 4'd8;
    localparam logic [3:0] KIND_PEND   = 4'd9;
    localparam logic [3:0] KIND_IGN    = 4'd10;

    // Decoder phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_NOTE = 3'd1;
    localparam logic [2:0] PH_PROG = 3'd2;
    localparam logic [2:0] PH_CTRL = 3'd3;
    localparam logic [2:0] PH_LONG = 3'd4;

    // Command byte fields
    localparam logic [2:0] TOP_PROG   = 3'b101;
    localparam logic [2:0] TOP_MARKER = 3'b110;
    localparam logic [2:0] TOP_NOTE_MAX = 3'b100;
    localparam logic [7:0] BYTE_STOP  = 8'hFF;
    localparam logic [1:0] SUB_LEND   = 2'd0;
    localparam logic [1:0] SUB_LSTART = 2'd1;
    localparam logic [1:0] SUB_SEND   = 2'd2;
    localparam logic [2:0] DELAY_LONG = 3'd7;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] held_byte;
        logic [7:0] delay_left;
        logic       active;
    } dec_state_t;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [2:0] channel;
        logic [6:0] note;
        logic [7:0] value;
        logic [1:0] controller_type;
        logic       playing;
        logic       ready_res;
    } dec_result_t;

endpackage

[sv/cmsd_decode.sv]
module cmsd_decode (
    input  logic [1:0]           action,
    input  logic [7:0]           data_byte,
    input  cmsd_pkg::dec_state_t state_cur,
    output cmsd_pkg::dec_state_t state_next,
    output cmsd_pkg::dec_result_t result
);
    import cmsd_pkg::*;

    logic [7:0] h;
    logic [7:0] b;
    logic [2:0] delay_field;

    assign h           = state_cur.held_byte;
    assign b           = data_byte;
    assign delay_field = b[4:2];

    // Decode one item against the current state
    always_comb begin
        state_next = state_cur;
        result     = '0;
        result.event_kind = KIND_IGN;

        unique case (action)
            ACT_TICK: begin
                if (state_cur.active) begin
                    if (state_cur.delay_left != 8'd0) begin
                        state_next.delay_left = state_cur.delay_left - 8'd1;
                    end
                    result.event_kind = KIND_TICK;
                    result.value      = state_next.delay_left;
                end
            end
            ACT_START: begin
                state_next.active     = 1'b1;
                state_next.phase      = PH_IDLE;
                state_next.held_byte  = 8'd0;
                state_next.delay_left = 8'd0;
            end
            ACT_STOP: begin
                state_next.active = 1'b0;
                state_next.phase  = PH_IDLE;
            end
            ACT_BYTE: begin
                if (state_cur.active && state_cur.delay_left == 8'd0) begin
                    state_next.phase = PH_IDLE;
                    unique case (state_cur.phase)
                        PH_NOTE: begin
                            result.event_kind = KIND_NOTE;
                            result.channel    = h[7:5];
                            result.note       = b[6:0];
                            result.value      = {b[7], h[4:0], 2'b00};
                        end
                        PH_PROG: begin
                            result.event_kind = KIND_PROG;
                            result.channel    = h[2:0];
                            result.value      = b;
                        end
                        PH_CTRL: begin
                            result.event_kind      = KIND_CTRL;
                            result.channel         = h[2:0];
                            result.value           = {b[6:0], 1'b0};
                            result.controller_type = h[4:3];
                        end
                        PH_LONG: begin
                            state_next.delay_left = b;
                            result.event_kind     = KIND_DELAY;
                            result.value          = b;
                        end
                        default: begin
                            // Command byte
                            state_next.held_byte = b;
                            if (b == BYTE_STOP) begin
                                state_next.active = 1'b0;
                                result.event_kind = KIND_UNK;
                            end else if (b[7:5] <= TOP_NOTE_MAX) begin
                                state_next.phase  = PH_NOTE;
                                result.event_kind = KIND_PEND;
                            end else if (b[7:5] == TOP_PROG) begin
                                state_next.phase  = PH_PROG;
                                result.event_kind = KIND_PEND;
                            end else if (b[7:5] == TOP_MARKER) begin
                                unique case (b[1:0])
                                    SUB_LEND:   result.event_kind = KIND_LEND;
                                    SUB_LSTART: result.event_kind = KIND_LSTART;
                                    SUB_SEND: begin
                                        state_next.active = 1'b0;
                                        result.event_kind = KIND_SEND;
                                    end
                                    default: begin
                                        if (delay_field == DELAY_LONG) begin
                                            state_next.phase  = PH_LONG;
                                            result.event_kind = KIND_PEND;
                                        end else begin
                                            state_next.delay_left =
                                                {5'd0, delay_field} + 8'd1;
                                            result.event_kind = KIND_DELAY;
                                            result.value = {5'd0, delay_field} + 8'd1;
                                        end
                                    end
                                endcase
                            end else begin
                                state_next.phase  = PH_CTRL;
                                result.event_kind = KIND_PEND;
                            end
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Status after this item
        result.playing   = state_next.active;
        result.ready_res = state_next.active && (state_next.delay_left == 8'd0);
    end

endmodule

[sv/compact_music_stream_decoder.sv]
// Compact music stream decoder.
// Input channel (s_): one beat carries an action (stream byte, frame tick,
// start song, stop song) and a data byte used with stream bytes.
// Result channel (m_): every input beat yields exactly one result beat with
// the event kind, channel, note, value, controller type and the playback
// status after that beat (m_playing, m_ready_res).
// Path: an accepted beat is held in an input register, then decoded against
// the decoder state and placed in the result register.
// Throughput: one beat per cycle while the receiver keeps m_ready high; the
// decode is a single pass of masks and compares on the small state register.
// Reset (aresetn low, synchronous): both pipeline stages empty, playback
// inactive, phase idle, held byte and pending delay cleared.
// Receiver stall: the result register holds its beat; the input register
// fills one more beat and then s_ready drops until m_ready returns.
module compact_music_stream_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_event_kind,
    output logic [2:0] m_channel,
    output logic [6:0] m_note,
    output logic [7:0] m_value,
    output logic [1:0] m_controller_type,
    output logic       m_playing,
    output logic       m_ready_res
);
    import cmsd_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  action_reg;
    logic [7:0]  data_byte_reg;
    logic        out_valid_reg;
    dec_result_t result_reg;
    dec_result_t result_next;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    logic        out_adv;
    logic        in_adv;

    // Pipeline advance
    assign out_adv = !out_valid_reg || m_ready;
    assign in_adv  = !in_valid_reg || out_adv;
    assign s_ready = in_adv;

    cmsd_decode u_decode (
        .action     (action_reg),
        .data_byte  (data_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Input register: capture a beat whenever the stage frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_valid;
        end
        if (in_adv && s_valid) begin
            action_reg    <= s_action;
            data_byte_reg <= s_data_byte;
        end
    end

    // Decode stage: advance state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
        if (out_adv && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_kind      = result_reg.event_kind;
    assign m_channel         = result_reg.channel;
    assign m_note            = result_reg.note;
    assign m_value           = result_reg.value;
    assign m_controller_type = result_reg.controller_type;
    assign m_playing         = result_reg.playing;
    assign m_ready_res       = result_reg.ready_res;

endmodule

[dv/compact_music_stream_decoder_checker.sv]
`timescale 1ns / 1ps

module compact_music_stream_decoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_event_kind,
    input  logic [2:0] m_channel,
    input  logic [6:0] m_note,
    input  logic [7:0] m_value,
    input  logic [1:0] m_controller_type,
    input  logic       m_playing,
    input  logic       m_ready_res,
    output int         fail_count,
    output int         events_due
);
    import cmsd_pkg::*;

    // Mirror of the decoder state
    logic [2:0] cur_phase;
    logic [7:0] cmd_byte;
    logic [7:0] frames_left;
    logic       is_playing;

    dec_result_t expected_events[$];
    int          mismatches;

    // Decode one beat against the mirrored state and advance it
    function automatic dec_result_t decode_event(input logic [1:0] act, input logic [7:0] b);
        dec_result_t r;
        r = '0;
        r.event_kind = KIND_IGN;
        case (act)
            ACT_TICK: begin
                if (is_playing) begin
                    if (frames_left != 8'd0) frames_left = frames_left - 8'd1;
                    r.event_kind = KIND_TICK;
                    r.value      = frames_left;
                end
            end
            ACT_START: begin
                is_playing  = 1'b1;
                cur_phase   = PH_IDLE;
                cmd_byte    = 8'h00;
                frames_left = 8'h00;
            end
            ACT_STOP: begin
                is_playing = 1'b0;
                cur_phase  = PH_IDLE;
            end
            ACT_BYTE: begin
                if (is_playing && frames_left == 8'd0) begin
                    case (cur_phase)
                        PH_NOTE: begin
                            cur_phase    = PH_IDLE;
                            r.event_kind = KIND_NOTE;
                            r.channel    = cmd_byte[7:5];
                            r.note       = b[6:0];
                            r.value      = {b[7], cmd_byte[4:0], 2'b00};
                        end
                        PH_PROG: begin
                            cur_phase    = PH_IDLE;
                            r.event_kind = KIND_PROG;
                            r.channel    = cmd_byte[2:0];
                            r.value      = b;
                        end
                        PH_CTRL: begin
                            cur_phase         = PH_IDLE;
                            r.event_kind      = KIND_CTRL;
                            r.channel         = cmd_byte[2:0];
                            r.value           = {b[6:0], 1'b0};
                            r.controller_type = cmd_byte[4:3];
                        end
                        PH_LONG: begin
                            cur_phase    = PH_IDLE;
                            frames_left  = b;
                            r.event_kind = KIND_DELAY;
                            r.value      = b;
                        end
                        default: begin
                            // Command byte: idle and unused phase codes alike
                            cur_phase = PH_IDLE;
                            cmd_byte  = b;
                            if (b == BYTE_STOP) begin
                                is_playing   = 1'b0;
                                r.event_kind = KIND_UNK;
                            end else if (b[7:5] <= TOP_NOTE_MAX) begin
                                cur_phase    = PH_NOTE;
                                r.event_kind = KIND_PEND;
                            end else if (b[7:5] == TOP_PROG) begin
                                cur_phase    = PH_PROG;
                                r.event_kind = KIND_PEND;
                            end else if (b[7:5] == TOP_MARKER) begin
                                case (b[1:0])
                                    SUB_LEND:   r.event_kind = KIND_LEND;
                                    SUB_LSTART: r.event_kind = KIND_LSTART;
                                    SUB_SEND: begin
                                        is_playing   = 1'b0;
                                        r.event_kind = KIND_SEND;
                                    end
                                    default: begin
                                        if (b[4:2] == DELAY_LONG) begin
                                            cur_phase    = PH_LONG;
                                            r.event_kind = KIND_PEND;
                                        end else begin
                                            frames_left  = {5'd0, b[4:2]} + 8'd1;
                                            r.event_kind = KIND_DELAY;
                                            r.value      = frames_left;
                                        end
                                    end
                                endcase
                            end else begin
                                cur_phase    = PH_CTRL;
                                r.event_kind = KIND_PEND;
                            end
                        end
                    endcase
                end
            end
        endcase
        r.playing   = is_playing;
        r.ready_res = is_playing && (frames_left == 8'd0);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Score result beats, then queue predictions for accepted input beats
    always @(posedge aclk) begin
        dec_result_t want;
        dec_result_t got;
        if (!aresetn) begin
            cur_phase   = PH_IDLE;
            cmd_byte    = 8'h00;
            frames_left = 8'h00;
            is_playing  = 1'b0;
            expected_events.delete();
            mismatches  = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_event_kind, m_channel, m_note, m_value, m_controller_type,
                       m_playing, m_ready_res};
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, got kind %0d",
                             $time, got.event_kind);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
                    check_field("channel", 8'(want.channel), 8'(got.channel));
                    check_field("note", 8'(want.note), 8'(got.note));
                    check_field("value", want.value, got.value);
                    check_field("controller_type", 8'(want.controller_type),
                                8'(got.controller_type));
                    check_field("playing", 8'(want.playing), 8'(got.playing));
                    check_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
                end
            end
            if (s_valid && s_ready) begin
                expected_events.push_back(decode_event(s_action, s_data_byte));
            end
        end
        fail_count <= mismatches;
        events_due <= expected_events.size();
    end

endmodule

[dv/compact_music_stream_decoder_tb.sv]
`timescale 1ns / 1ps

module compact_music_stream_decoder_tb;
    import cmsd_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int BEAT_TARGET  = 600;
    localparam int HOLD_AT      = 200;
    localparam int DRAIN_AT     = 420;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_action;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_event_kind;
    logic [2:0] m_channel;
    logic [6:0] m_note;
    logic [7:0] m_value;
    logic [1:0] m_controller_type;
    logic       m_playing;
    logic       m_ready_res;
    int         fail_count;
    int         events_due;

    int  beats_offered;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_results;

    compact_music_stream_decoder u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_channel         (m_channel),
        .m_note            (m_note),
        .m_value           (m_value),
        .m_controller_type (m_controller_type),
        .m_playing         (m_playing),
        .m_ready_res       (m_ready_res)
    );

    compact_music_stream_decoder_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_channel         (m_channel),
        .m_note            (m_note),
        .m_value           (m_value),
        .m_controller_type (m_controller_type),
        .m_playing         (m_playing),
        .m_ready_res       (m_ready_res),
        .fail_count        (fail_count),
        .events_due        (events_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one beat after a random gap; return at the falling edge after acceptance
    task automatic offer_beat(input logic [1:0] act, input logic [7:0] data);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_offered++;
        if (beats_offered % 40 == 0) src_idle_on = ($urandom_range(0, 3) != 0);
    endtask

    task automatic offer_byte(input logic [7:0] data);
        offer_beat(ACT_BYTE, data);
    endtask

    task automatic offer_tick();
        offer_beat(ACT_TICK, 8'($urandom));
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (events_due == 0);
        @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        int taken;
        m_ready      = 1'b0;
        sink_idle_on = 1'b1;
        taken        = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_results = 1'b0;
            end
            stall = sink_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            taken++;
            if (taken % 30 == 0) sink_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [9:0] directed[$];
        logic [7:0] cmd;
        int         pick;
        int         n;
        bit         hold_done;
        bit         drain_done;

        s_valid       = 1'b0;
        s_action      = ACT_BYTE;
        s_data_byte   = 8'h00;
        aresetn       = 1'b0;
        beats_offered = 0;
        src_idle_on   = 1'b1;
        hold_results  = 1'b0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes, each event, tick and stop corner cases
        directed = '{
            {ACT_BYTE, 8'h00},                                       // byte before start
            {ACT_START, 8'h00},
            {ACT_BYTE, 8'h00}, {ACT_BYTE, 8'h00},                    // silent note
            {ACT_BYTE, 8'h9F}, {ACT_BYTE, 8'hFF},                    // loudest, top note
            {ACT_BYTE, 8'hA7}, {ACT_TICK, 8'hFF}, {ACT_BYTE, 8'hFF}, // tick mid-event
            {ACT_BYTE, 8'hFE}, {ACT_BYTE, 8'hFF},                    // controller max
            {ACT_BYTE, 8'hC0}, {ACT_BYTE, 8'hC1},                    // loop markers
            {ACT_BYTE, 8'hC7}, {ACT_BYTE, 8'h55},                    // byte while waiting
            {ACT_TICK, 8'h00}, {ACT_TICK, 8'h00}, {ACT_TICK, 8'h00}, // extra tick
            {ACT_BYTE, 8'hDF}, {ACT_BYTE, 8'h00},                    // long delay of zero
            {ACT_BYTE, 8'hC2}, {ACT_TICK, 8'h00}, {ACT_STOP, 8'h00}, // song end
            {ACT_START, 8'h00}, {ACT_BYTE, 8'hFF},                   // unknown stop
            {ACT_START, 8'h00}, {ACT_BYTE, 8'hA0}, {ACT_STOP, 8'h00} // dropped event
        };
        foreach (directed[i]) offer_beat(directed[i][9:8], directed[i][7:0]);

        // Random: mostly well-formed events with random content
        offer_beat(ACT_START, 8'($urandom));
        while (beats_offered < BEAT_TARGET) begin
            if (!hold_done && beats_offered >= HOLD_AT) begin
                hold_results = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && beats_offered >= DRAIN_AT) begin
                drain_results();
                drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                cmd = {3'($urandom_range(0, 4)), 5'($urandom)};
                offer_byte(cmd);
                offer_byte(8'($urandom));
            end else if (pick < 35) begin
                offer_byte({TOP_PROG, 5'($urandom)});
                offer_byte(8'($urandom));
            end else if (pick < 50) begin
                offer_byte({3'b111, 5'($urandom_range(0, 30))});
                offer_byte(8'($urandom));
            end else if (pick < 58) begin
                offer_byte({TOP_MARKER, 3'($urandom), 1'b0, 1'($urandom)});
            end else if (pick < 70) begin
                n = $urandom_range(0, 6);
                offer_byte({TOP_MARKER, 3'(n), 2'b11});
                repeat (n + 1) begin
                    if ($urandom_range(0, 7) == 0) offer_byte(8'($urandom));
                    offer_tick();
                end
            end else if (pick < 78) begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
                offer_byte({TOP_MARKER, DELAY_LONG, 2'b11});
                offer_byte(8'(n));
                repeat (n) offer_tick();
            end else if (pick < 83) begin
                offer_tick();
            end else if (pick < 88) begin
                cmd = ($urandom_range(0, 1) != 0) ? {TOP_MARKER, 3'($urandom), SUB_SEND}
                                                  : BYTE_STOP;
                offer_byte(cmd);
                if ($urandom_range(0, 1) != 0) offer_beat(2'($urandom_range(0, 1)), 8'($urandom));
                offer_beat(ACT_START, 8'($urandom));
            end else if (pick < 94) begin
                // Broken event: command byte cut off by a start or stop
                offer_byte(8'($urandom_range(0, 254)));
                offer_beat(($urandom_range(0, 1) != 0) ? ACT_STOP : ACT_START, 8'($urandom));
                offer_beat(ACT_START, 8'($urandom));
            end else begin
                offer_beat(2'($urandom), 8'($urandom));
                offer_beat(ACT_START, 8'($urandom));
            end
        end

        // Flush and give the verdict
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (events_due == 0);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
